/* rtl/mst_pkg.sv */
// mst_pkg: shared types and constants of the multi-slot timer table
// command and status codes, slot states, and the token passed down the cell chain
// no dependencies
package mst_pkg;

   localparam int SLOT_COUNT = 8;
   localparam int IDX_W      = 8;
   localparam logic [IDX_W-1:0] SLOT_LIMIT = IDX_W'(SLOT_COUNT);

   // command codes
   localparam logic [2:0] CMD_CREATE = 3'd0;
   localparam logic [2:0] CMD_START  = 3'd1;
   localparam logic [2:0] CMD_CANCEL = 3'd2;
   localparam logic [2:0] CMD_PAUSE  = 3'd3;
   localparam logic [2:0] CMD_FREE   = 3'd4;
   localparam logic [2:0] CMD_TICK   = 3'd5;

   // reply status codes
   localparam logic [1:0] RS_OK           = 2'd0;
   localparam logic [1:0] RS_BAD_INSTANCE = 2'd1;
   localparam logic [1:0] RS_WRONG_STATE  = 2'd2;
   localparam logic [1:0] RS_NO_FREE      = 2'd3;

   // result kinds
   localparam logic KIND_REPLY   = 1'b0;
   localparam logic KIND_TIMEOUT = 1'b1;

   // slot states
   localparam logic [1:0] ST_INACTIVE   = 2'd0;
   localparam logic [1:0] ST_CONFIGURED = 2'd1;
   localparam logic [1:0] ST_RUNNING    = 2'd2;
   localparam logic [1:0] ST_DONE       = 2'd3;

   // command token travelling through the cells
   typedef struct packed {
      logic             valid;
      logic [2:0]       cmd;
      logic [IDX_W-1:0] idx;
      logic [30:0]      ivl;
      logic             per;
      logic             ntf;
      logic [31:0]      now;
      logic             hit;     // create found a slot
      logic [1:0]       status;
      logic [IDX_W-1:0] slot;
   } token_type;

   // timeout event raised by one cell
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] slot;
   } event_type;

endpackage

/* rtl/mst_cell.sv */
// mst_cell: one timer slot of the chain, holds the slot state and one token stage
// applies the token's command to its own slot and hands the token to the next cell
// depends on mst_pkg
module mst_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic [mst_pkg::IDX_W-1:0]    cell_index,
   input  mst_pkg::token_type           tok_in,
   output mst_pkg::token_type           tok_out,
   output mst_pkg::event_type           ev_out
);

   mst_pkg::token_type tok_ff;
   logic [1:0]  state_ff, state_in;
   logic [31:0] due_ff, due_in;
   logic [30:0] ivl_ff, ivl_in;
   logic        per_ff, per_in;
   logic        ntf_ff, ntf_in;
   logic        match;
   logic        expired;

   assign match   = tok_ff.idx == cell_index;
   assign expired = (state_ff == mst_pkg::ST_RUNNING) && (tok_ff.now > due_ff);

   always_comb begin
      tok_out  = tok_ff;
      ev_out   = '0;
      state_in = state_ff;
      due_in   = due_ff;
      ivl_in   = ivl_ff;
      per_in   = per_ff;
      ntf_in   = ntf_ff;
      if (tok_ff.valid) begin
         case (tok_ff.cmd)
            mst_pkg::CMD_CREATE: begin
               if (!tok_ff.hit && state_ff == mst_pkg::ST_INACTIVE) begin
                  state_in       = mst_pkg::ST_CONFIGURED;
                  ivl_in         = tok_ff.ivl;
                  per_in         = tok_ff.per;
                  ntf_in         = tok_ff.ntf;
                  tok_out.hit    = 1'b1;
                  tok_out.status = mst_pkg::RS_OK;
                  tok_out.slot   = cell_index;
               end
            end
            mst_pkg::CMD_START: begin
               if (match) begin
                  if (state_ff == mst_pkg::ST_INACTIVE) begin
                     tok_out.status = mst_pkg::RS_BAD_INSTANCE;
                  end else if (state_ff == mst_pkg::ST_CONFIGURED) begin
                     due_in         = tok_ff.now + {1'b0, ivl_ff};
                     state_in       = mst_pkg::ST_RUNNING;
                     tok_out.status = mst_pkg::RS_OK;
                  end else begin
                     tok_out.status = mst_pkg::RS_WRONG_STATE;
                  end
               end
            end
            mst_pkg::CMD_CANCEL: begin
               if (match) begin
                  if (state_ff == mst_pkg::ST_RUNNING) begin
                     state_in       = mst_pkg::ST_CONFIGURED;
                     tok_out.status = mst_pkg::RS_OK;
                  end else begin
                     tok_out.status = mst_pkg::RS_WRONG_STATE;
                  end
               end
            end
            mst_pkg::CMD_PAUSE: begin
               if (match) begin
                  tok_out.status = (state_ff == mst_pkg::ST_DONE) ?
                                   mst_pkg::RS_WRONG_STATE : mst_pkg::RS_OK;
               end
            end
            mst_pkg::CMD_FREE: begin
               if (match) begin
                  if (state_ff == mst_pkg::ST_INACTIVE) begin
                     tok_out.status = mst_pkg::RS_BAD_INSTANCE;
                  end else begin
                     state_in       = mst_pkg::ST_INACTIVE;
                     due_in         = '0;
                     ntf_in         = 1'b0;
                     tok_out.status = mst_pkg::RS_OK;
                  end
               end
            end
            mst_pkg::CMD_TICK: begin
               if (expired) begin
                  ev_out.valid = ntf_ff;
                  ev_out.slot  = cell_index;
                  if (per_ff) begin
                     due_in = due_ff + {1'b0, ivl_ff};
                  end else begin
                     state_in = mst_pkg::ST_DONE;
                  end
               end
            end
            default: begin
               // unused codes pass through untouched
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
         state_ff     <= mst_pkg::ST_INACTIVE;
      end else if (advance) begin
         tok_ff   <= tok_in;
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         due_ff <= due_in;
         ivl_ff <= ivl_in;
         per_ff <= per_in;
         ntf_ff <= ntf_in;
      end
   end

endmodule

/* rtl/multi_slot_software_timer.sv */
// multi_slot_software_timer: top level of the multi-slot timer table
// chain of mst_cell slots, end stage, timeout hold register and result register
// depends on mst_pkg and mst_cell
//
// usage
//   req_* carries one command per transfer: create, start, cancel, pause, free
//   or tick. rsp_* returns results: one reply (kind 0) per command other than
//   tick, and for tick one timeout event (kind 1) per expired slot with notify
//   set, in slot order; rsp_last marks the final result of a command. a tick
//   with no expired notifying slot returns nothing, as do command codes six
//   and seven.
//   a command enters the first cell and moves one cell per cycle unless the
//   result register is stalled, each cell acting on its own slot; after the
//   last cell it reaches an end stage that builds the reply. one command is
//   in flight at a time: req_ready is high only when the chain is empty, so
//   a new command is accepted only after the last one leaves the end stage,
//   a wait set by the length of the cell chain.
//   timeout events are held one deep so the last one can be flagged; when the
//   receiver stalls with a result waiting, the token freezes in the chain
//   until rsp_ready frees the result register.
//   reset (synchronous) marks every slot inactive and empties the chain.
module multi_slot_software_timer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [7:0]  req_slot_index,
   input  logic [30:0] req_interval,
   input  logic        req_periodic,
   input  logic        req_notify_enable,
   input  logic [31:0] req_now_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_slot_out,
   output logic        rsp_last
);

   // token links between cells, entry 0 fed from the request port
   mst_pkg::token_type tok_link [mst_pkg::SLOT_COUNT+1];
   mst_pkg::token_type tok_head;
   mst_pkg::event_type ev_cell  [mst_pkg::SLOT_COUNT];
   mst_pkg::event_type ev_any;
   mst_pkg::token_type end_ff;

   logic                        busy_ff;
   logic                        hold_valid_ff;
   logic [mst_pkg::IDX_W-1:0]   hold_slot_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_kind_ff;
   logic [1:0]                  rsp_status_ff;
   logic [7:0]                  rsp_slot_ff;
   logic                        rsp_last_ff;

   logic                        out_free;
   logic                        need_push;
   logic                        advance;
   logic                        push;
   logic                        push_kind;
   logic [1:0]                  push_status;
   logic [7:0]                  push_slot;
   logic                        push_last;
   logic                        end_emits;
   logic [mst_pkg::SLOT_COUNT:0] tok_valid_vec;

   // request side: accept only with an empty chain
   assign req_ready = !busy_ff;

   always_comb begin
      tok_head        = '0;
      tok_head.valid  = req_valid && req_ready;
      tok_head.cmd    = req_command;
      tok_head.idx    = req_slot_index;
      tok_head.ivl    = req_interval;
      tok_head.per    = req_periodic;
      tok_head.ntf    = req_notify_enable;
      tok_head.now    = req_now_time;
      // out-of-range index is settled here; no cell will match it
      tok_head.status = (req_slot_index >= mst_pkg::SLOT_LIMIT) ?
                        mst_pkg::RS_BAD_INSTANCE : mst_pkg::RS_OK;
   end

   assign tok_link[0] = tok_head;

   // the row of slot cells
   for (genvar i = 0; i < mst_pkg::SLOT_COUNT; i++) begin : g_cell
      mst_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .cell_index (mst_pkg::IDX_W'(i)),
         .tok_in     (tok_link[i]),
         .tok_out    (tok_link[i+1]),
         .ev_out     (ev_cell[i])
      );
   end

   // only one token is in flight, so at most one cell raises an event
   always_comb begin
      ev_any = '0;
      for (int k = 0; k < mst_pkg::SLOT_COUNT; k++) begin
         ev_any = ev_any | ev_cell[k];
      end
   end

   always_comb begin
      for (int k = 0; k < mst_pkg::SLOT_COUNT; k++) begin
         tok_valid_vec[k] = tok_link[k+1].valid;
      end
      tok_valid_vec[mst_pkg::SLOT_COUNT] = end_ff.valid;
   end

   // end stage: tick flushes the held event, other known commands reply
   assign end_emits = end_ff.valid &&
                      ((end_ff.cmd == mst_pkg::CMD_TICK) ? hold_valid_ff :
                       (end_ff.cmd <= mst_pkg::CMD_FREE));

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign need_push = (ev_any.valid && hold_valid_ff) || end_emits;
   assign advance   = !need_push || out_free;
   assign push      = need_push && out_free;

   always_comb begin
      push_kind   = mst_pkg::KIND_TIMEOUT;
      push_status = mst_pkg::RS_OK;
      push_slot   = hold_slot_ff;
      push_last   = 1'b0;
      if (end_ff.valid) begin
         push_last = 1'b1;
         if (end_ff.cmd != mst_pkg::CMD_TICK) begin
            push_kind = mst_pkg::KIND_REPLY;
            if (end_ff.cmd == mst_pkg::CMD_CREATE && !end_ff.hit) begin
               push_status = mst_pkg::RS_NO_FREE;
               push_slot   = '0;
            end else begin
               push_status = end_ff.status;
               push_slot   = end_ff.slot;
            end
         end
      end
   end

   // control: busy flag, end stage, hold register, result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         end_ff.valid  <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (tok_head.valid) begin
            busy_ff <= 1'b1;
         end else if (advance && end_ff.valid) begin
            busy_ff <= 1'b0;
         end
         if (advance) begin
            end_ff <= tok_link[mst_pkg::SLOT_COUNT];
            if (end_ff.valid) begin
               hold_valid_ff <= 1'b0;
            end else if (ev_any.valid) begin
               hold_valid_ff <= 1'b1;
            end
         end
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (advance && ev_any.valid) begin
         hold_slot_ff <= ev_any.slot;
      end
      if (push) begin
         rsp_kind_ff   <= push_kind;
         rsp_status_ff <= push_status;
         rsp_slot_ff   <= push_slot;
         rsp_last_ff   <= push_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_slot_out = rsp_slot_ff;
   assign rsp_last     = rsp_last_ff;

   // never more than one command token in the chain
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_valid_vec))
      else $error("more than one token in the cell chain");

   // an idle block has an empty chain
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (tok_valid_vec == '0))
      else $error("token in chain while idle");

   // a held timeout exists only while a tick is in flight
   a_hold_busy: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> busy_ff)
      else $error("held timeout without an active command");

   // every command reply is the final result of its command
   a_reply_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == mst_pkg::KIND_REPLY) |-> rsp_last)
      else $error("reply without last flag");

   // the end stage leaves the chain free on the following cycle
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (end_ff.valid && advance) |=> !busy_ff)
      else $error("busy stuck after end stage");

endmodule
